@@ rtl/balanced_brace_body_scanner_top_macros.svh @@
// assertion macros for the brace body scanner
`ifndef BALANCED_BRACE_BODY_SCANNER_TOP_MACROS_SVH
`define BALANCED_BRACE_BODY_SCANNER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while in reset
`define BBS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brace scanner assertion failed");
// next-cycle implication
`define BBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brace scanner assertion failed");
`else
`define BBS_ASSERT_SAME(label, ante, cons)
`define BBS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/bbs_pkg.sv @@
package bbs_pkg;

    // defaults for the top-level parameters
    localparam int DEPTH_BITS_DEF  = 16;
    localparam int LENGTH_BITS_DEF = 32;

    // width of the reported length
    localparam int OUT_LEN_BITS = 32;

    // queue depth is 2**QUEUE_ADDR_BITS
    localparam int QUEUE_ADDR_BITS = 2;

    // byte classes passed from front to back
    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_SPACE,
        CLS_NEWLINE,
        CLS_LBRACE,
        CLS_RBRACE,
        CLS_QUOTE,
        CLS_SLASH,
        CLS_STAR,
        CLS_BSLASH,
        CLS_EOI
    } byte_class_t;

    typedef enum logic [1:0] {
        OUT_CONTENT  = 2'd0,
        OUT_EMPTY    = 2'd1,
        OUT_UNCLOSED = 2'd2,
        OUT_OVERFLOW = 2'd3
    } outcome_t;

    typedef struct packed {
        outcome_t                  outcome;
        logic [OUT_LEN_BITS-1:0]   body_length;
    } result_t;

endpackage

@@ rtl/balanced_brace_body_scanner_top.sv @@
// brace body scanner: takes the bytes after an opening brace, one request per
// cycle while the input queue is not full, and finds the matching closing brace
// while skipping double-quoted strings (ended by a quote or newline, backslash
// escapes one byte), line comments and nested block comments; one result
// request comes out per body, giving the outcome (content, empty body, unclosed
// at end of input, nesting overflow) and the saturating body length, after
// which the scanner is back at rest; the back-end scanner updates its state
// once per item taken; a result is written into the output queue as the
// scanner takes the closing request off the middle queue; four-entry queues sit
// between front end, scanner and result port, so either side may stall alone

`include "balanced_brace_body_scanner_top_macros.svh"

module balanced_brace_body_scanner_top
    import bbs_pkg::*;
#(
    parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input request queue
    input  logic [7:0]              text_byte,
    input  logic                    end_of_input,
    input  logic                    push,
    output logic                    full,
    // result request queue
    output logic [1:0]              outcome,
    output logic [OUT_LEN_BITS-1:0] body_length,
    output logic                    empty,
    input  logic                    pop
);

    // classified byte between front end and scanner
    byte_class_t front_item;
    byte_class_t mid_item;
    logic [$bits(byte_class_t)-1:0] mid_bits;
    logic        mid_push;
    logic        mid_full;
    logic        mid_pop;
    logic        mid_empty;

    // finished results
    result_t     res_in;
    result_t     res_out;
    logic        res_push;
    logic        out_full;

    // front end: handshake and byte classification
    bbs_front u_front
    (
        .text_byte    (text_byte),
        .end_of_input (end_of_input),
        .push         (push),
        .full         (full),
        .mid_full     (mid_full),
        .mid_push     (mid_push),
        .mid_item     (front_item)
    );

    // decoupling queue of classified bytes
    bbs_fifo #(
        .WIDTH     ($bits(byte_class_t)),
        .ADDR_BITS (QUEUE_ADDR_BITS)
    ) u_mid_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (front_item),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_bits),
        .empty   (mid_empty)
    );

    // queue head back to its class
    assign mid_item = byte_class_t'(mid_bits);

    // scanner: lexical modes, brace and comment depth, length count
    bbs_back #(
        .DEPTH_BITS  (DEPTH_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (mid_item),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue, the head drives the output ports
    bbs_fifo #(
        .WIDTH     ($bits(result_t)),
        .ADDR_BITS (QUEUE_ADDR_BITS)
    ) u_out_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (out_full),
        .rd_en   (pop && !empty),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign outcome     = res_out.outcome;
    assign body_length = res_out.body_length;

    // a result only ever comes from a byte taken off the middle queue
    `BBS_ASSERT_SAME(a_result_needs_item, res_push, mid_pop)
    // the scanner never reads an empty middle queue
    `BBS_ASSERT_SAME(a_no_read_empty, mid_pop, !mid_empty)
    // a result is never pushed into a full result queue
    `BBS_ASSERT_SAME(a_no_result_overrun, res_push, !out_full)
    // an accepted request is waiting in the middle queue on the next cycle
    `BBS_ASSERT_NEXT(a_accept_lands, push && !full, !mid_empty)

endmodule

@@ rtl/bbs_fifo.sv @@
module bbs_fifo
    import bbs_pkg::*;
#(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = QUEUE_ADDR_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int ENTRIES = 1 << ADDR_BITS;

    logic [WIDTH-1:0]     mem [ENTRIES];
    logic [ADDR_BITS-1:0] wr_ptr_reg;
    logic [ADDR_BITS-1:0] rd_ptr_reg;
    logic [ADDR_BITS:0]   count_reg;
    logic [ADDR_BITS:0]   count_next;

    assign full    = (count_reg == (ADDR_BITS+1)'(ENTRIES));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/bbs_front.sv @@
module bbs_front
    import bbs_pkg::*;
(
    input  logic        [7:0] text_byte,
    input  logic              end_of_input,
    input  logic              push,
    output logic              full,
    input  logic              mid_full,
    output logic              mid_push,
    output byte_class_t       mid_item
);

    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_VTAB    = 8'h0B;
    localparam logic [7:0] CHAR_FF      = 8'h0C;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE  = 8'h7D;

    assign full     = mid_full;
    assign mid_push = push && !mid_full;

    // end of input wins over the byte
    always_comb
    begin
        if (end_of_input)
        begin
            mid_item = CLS_EOI;
        end
        else
        begin
            unique case (text_byte)
                CHAR_LBRACE:  mid_item = CLS_LBRACE;
                CHAR_RBRACE:  mid_item = CLS_RBRACE;
                CHAR_QUOTE:   mid_item = CLS_QUOTE;
                CHAR_SLASH:   mid_item = CLS_SLASH;
                CHAR_STAR:    mid_item = CLS_STAR;
                CHAR_BSLASH:  mid_item = CLS_BSLASH;
                CHAR_NEWLINE: mid_item = CLS_NEWLINE;
                CHAR_TAB, CHAR_VTAB, CHAR_FF, CHAR_CR, CHAR_SPACE:
                              mid_item = CLS_SPACE;
                default:      mid_item = CLS_OTHER;
            endcase
        end
    end

endmodule

@@ rtl/bbs_back.sv @@
module bbs_back
    import bbs_pkg::*;
#(
    parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  byte_class_t item,
    input  logic        mid_empty,
    output logic        mid_pop,
    input  logic        out_full,
    output logic        res_push,
    output result_t     res
);

    typedef enum logic [2:0] {
        M_CODE,
        M_SLASH,
        M_LINE,
        M_STR,
        M_STR_ESC,
        M_BLK,
        M_BLK_SLASH,
        M_BLK_STAR
    } mode_t;

    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = '1;
    localparam logic [DEPTH_BITS-1:0]  DEPTH_ONE = DEPTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    mode_t                  mode_reg, mode_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    logic [DEPTH_BITS-1:0]  cdepth_reg, cdepth_next;
    logic                   content_reg, content_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   code_b;
    logic                   fin;
    outcome_t               fin_code;
    logic [OUT_LEN_BITS-1:0] len_out;

    // one item per cycle while the result queue has room
    assign mid_pop  = !mid_empty && !out_full;
    assign res_push = mid_pop && fin;

    generate
        if (LENGTH_BITS > OUT_LEN_BITS)
        begin : g_len_sat
            assign len_out = (|count_reg[LENGTH_BITS-1:OUT_LEN_BITS]) ? '1
                                                                       : count_reg[OUT_LEN_BITS-1:0];
        end
        else
        begin : g_len_ext
            assign len_out = OUT_LEN_BITS'(count_reg);
        end
    endgenerate

    assign res.outcome     = fin_code;
    assign res.body_length = len_out;

    always_comb
    begin
        mode_next    = mode_reg;
        depth_next   = depth_reg;
        cdepth_next  = cdepth_reg;
        content_next = content_reg;
        count_next   = count_reg;
        code_b       = 1'b0;
        fin          = 1'b0;
        fin_code     = OUT_CONTENT;

        if (mid_pop)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end

            if (item == CLS_EOI)
            begin
                fin      = 1'b1;
                fin_code = OUT_UNCLOSED;
            end
            else
            begin
                unique case (mode_reg)
                    M_CODE:
                    begin
                        code_b = 1'b1;
                    end
                    M_SLASH:
                    begin
                        if (item == CLS_SLASH)
                        begin
                            mode_next = M_LINE;
                        end
                        else if (item == CLS_STAR)
                        begin
                            mode_next   = M_BLK;
                            cdepth_next = DEPTH_ONE;
                        end
                        else
                        begin
                            mode_next = M_CODE;
                            code_b    = 1'b1;
                        end
                    end
                    M_LINE:
                    begin
                        // the newline itself is whitespace in code
                        if (item == CLS_NEWLINE)
                        begin
                            mode_next = M_CODE;
                        end
                    end
                    M_STR:
                    begin
                        if (item == CLS_QUOTE || item == CLS_NEWLINE)
                        begin
                            mode_next = M_CODE;
                        end
                        else if (item == CLS_BSLASH)
                        begin
                            mode_next = M_STR_ESC;
                        end
                    end
                    M_STR_ESC:
                    begin
                        mode_next = M_STR;
                    end
                    M_BLK:
                    begin
                        if (item == CLS_SLASH)
                        begin
                            mode_next = M_BLK_SLASH;
                        end
                        else if (item == CLS_STAR)
                        begin
                            mode_next = M_BLK_STAR;
                        end
                    end
                    M_BLK_SLASH:
                    begin
                        if (item == CLS_STAR)
                        begin
                            if (cdepth_reg == DEPTH_MAX)
                            begin
                                fin      = 1'b1;
                                fin_code = OUT_OVERFLOW;
                            end
                            else
                            begin
                                cdepth_next = cdepth_reg + 1'b1;
                                mode_next   = M_BLK;
                            end
                        end
                        else if (item != CLS_SLASH)
                        begin
                            mode_next = M_BLK;
                        end
                    end
                    M_BLK_STAR:
                    begin
                        if (item == CLS_SLASH)
                        begin
                            if (cdepth_reg <= DEPTH_ONE)
                            begin
                                cdepth_next = '0;
                                mode_next   = M_CODE;
                            end
                            else
                            begin
                                cdepth_next = cdepth_reg - 1'b1;
                                mode_next   = M_BLK;
                            end
                        end
                        else if (item != CLS_STAR)
                        begin
                            mode_next = M_BLK;
                        end
                    end
                endcase

                if (code_b)
                begin
                    unique case (item)
                        CLS_RBRACE:
                        begin
                            if (depth_reg <= DEPTH_ONE)
                            begin
                                fin      = 1'b1;
                                fin_code = content_reg ? OUT_CONTENT : OUT_EMPTY;
                            end
                            else
                            begin
                                depth_next = depth_reg - 1'b1;
                            end
                        end
                        CLS_LBRACE:
                        begin
                            if (depth_reg == DEPTH_MAX)
                            begin
                                fin      = 1'b1;
                                fin_code = OUT_OVERFLOW;
                            end
                            else
                            begin
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        CLS_QUOTE:
                        begin
                            content_next = 1'b1;
                            mode_next    = M_STR;
                        end
                        CLS_SLASH:
                        begin
                            content_next = 1'b1;
                            mode_next    = M_SLASH;
                        end
                        CLS_SPACE, CLS_NEWLINE:
                        begin
                        end
                        default:
                        begin
                            content_next = 1'b1;
                        end
                    endcase
                end
            end

            // back to rest after every result
            if (fin)
            begin
                mode_next    = M_CODE;
                depth_next   = DEPTH_ONE;
                cdepth_next  = '0;
                content_next = 1'b0;
                count_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_CODE;
            depth_reg   <= DEPTH_ONE;
            cdepth_reg  <= '0;
            content_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            depth_reg   <= depth_next;
            cdepth_reg  <= cdepth_next;
            content_reg <= content_next;
            count_reg   <= count_next;
        end
    end

endmodule
